// ----- hdl/stl_pkg.sv -----
// Shared types and character constants for the space-to-tab line compressor.
// No dependencies; imported by the controller, datapath and top level.
package stl_pkg;

	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_NEWLINE = 8'd10;

	typedef struct packed {
		logic take;
		logic newline;
		logic drop;
		logic raw_out;
		logic store_in;
		logic start_group;
		logic start_fill;
		logic hold_blank;
		logic put_char;
		logic rel_put;
		logic finish_group;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic in_end;
		logic in_full;
		logic comp;
		logic pos_nz;
		logic boundary;
		logic scan_done;
		logic cur_blank;
		logic pend_zero;
		logic rel_last;
	} sts_t;

endpackage

// ----- hdl/stl_dpath.sv -----
// Datapath of the line compressor: line position, group store, held-blank memory
// and the output register. Driven by stl_ctrl through cmd_t; depends on stl_pkg.
module stl_dpath
	import stl_pkg::*;
#(
	parameter int TAB_WIDTH = 8,
	parameter int LINE_MAX  = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_bit,
	input  logic       req_type,
	input  logic [7:0] char_byte,
	input  logic       result_stall,
	input  cmd_t       cmd,
	output sts_t       sts,
	output logic       result_valid,
	output logic [7:0] out_byte,
	output logic       line_end,
	output logic       overflow
);

	localparam int POS_W = $clog2(LINE_MAX + 1);
	localparam int AW    = $clog2(LINE_MAX);
	localparam int COL_W = $clog2(TAB_WIDTH);
	localparam int KW    = $clog2(TAB_WIDTH + 1);

	typedef enum logic [1:0] {XTRA_NONE, XTRA_SPACE, XTRA_TAB} xtra_t;

	logic             cfg_q;
	logic             line_comp_q;
	logic [POS_W-1:0] pos_q;
	logic [COL_W-1:0] col_q;
	logic             ovf_q;
	logic [POS_W-1:0] pcount_q;
	logic [AW-1:0]    rel_idx_q;
	logic [KW-1:0]    k_q;
	logic [KW-1:0]    limit_q;
	xtra_t            xtra_q;
	logic [7:0]       c_q;
	logic [7:0]       grp_q [TAB_WIDTH];
	logic             pend_mem [LINE_MAX];
	logic             rd_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             line_end_q;
	logic             overflow_q;

	logic [KW-1:0]    grp_lim;
	xtra_t            grp_xtra;
	logic [KW-1:0]    fill;
	logic             in_range;
	logic [7:0]       cur;
	logic [COL_W-1:0] col_next;
	logic             slot_free;
	logic             advance;
	logic             pend_wr;
	logic             out_load;

	always_comb begin
		grp_lim = '0;
		for (int i = 0; i < TAB_WIDTH; i++) begin
			if (grp_q[i] != CH_SPACE) begin
				grp_lim = KW'(i + 1);
			end
		end
	end

	always_comb begin
		if (grp_lim == KW'(TAB_WIDTH - 1)) begin
			grp_xtra = XTRA_SPACE;
		end else if (grp_lim < KW'(TAB_WIDTH - 1)) begin
			grp_xtra = XTRA_TAB;
		end else begin
			grp_xtra = XTRA_NONE;
		end
	end

	assign fill      = (col_q == '0) ? KW'(TAB_WIDTH) : KW'(col_q);
	assign in_range  = (k_q < limit_q);
	assign cur       = in_range ? grp_q[k_q[COL_W-1:0]]
	                            : ((xtra_q == XTRA_SPACE) ? CH_SPACE : CH_TAB);
	assign col_next  = (col_q == COL_W'(TAB_WIDTH - 1)) ? '0 : col_q + COL_W'(1);
	assign slot_free = !out_valid_q || !result_stall;
	assign advance   = cmd.hold_blank || cmd.put_char;
	assign pend_wr   = cmd.hold_blank && (pcount_q < POS_W'(LINE_MAX));
	assign out_load  = cmd.raw_out || cmd.put_char || cmd.rel_put || cmd.newline;

	always_comb begin
		sts.slot_free = slot_free;
		sts.in_end    = req_type;
		sts.in_full   = (pos_q >= POS_W'(LINE_MAX));
		sts.comp      = (pos_q == '0) ? cfg_q : line_comp_q;
		sts.pos_nz    = (pos_q != '0);
		sts.boundary  = (pos_q != '0) && (col_q == '0);
		sts.scan_done = !in_range && (xtra_q == XTRA_NONE);
		sts.cur_blank = (cur == CH_SPACE) || (cur == CH_TAB);
		sts.pend_zero = (pcount_q == '0);
		sts.rel_last  = ((POS_W'(rel_idx_q) + POS_W'(1)) == pcount_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= 1'b0;
			line_comp_q <= 1'b0;
			pos_q       <= '0;
			col_q       <= '0;
			ovf_q       <= 1'b0;
			pcount_q    <= '0;
			rel_idx_q   <= '0;
			k_q         <= '0;
			limit_q     <= '0;
			xtra_q      <= XTRA_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_bit;
			end
			if (cmd.take && (pos_q == '0)) begin
				line_comp_q <= cfg_q;
			end
			if (cmd.drop) begin
				ovf_q <= 1'b1;
			end
			if (cmd.raw_out || cmd.store_in || cmd.finish_group) begin
				pos_q <= pos_q + POS_W'(1);
				col_q <= col_next;
			end
			if (cmd.start_group) begin
				k_q     <= '0;
				limit_q <= grp_lim;
				xtra_q  <= grp_xtra;
			end
			if (cmd.start_fill) begin
				k_q     <= '0;
				limit_q <= fill;
				xtra_q  <= XTRA_NONE;
			end
			if (advance) begin
				if (in_range) begin
					k_q <= k_q + KW'(1);
				end else begin
					xtra_q <= XTRA_NONE;
				end
			end
			if (pend_wr) begin
				pcount_q <= pcount_q + POS_W'(1);
			end
			if (cmd.rel_put) begin
				if (sts.rel_last) begin
					pcount_q  <= '0;
					rel_idx_q <= '0;
				end else begin
					rel_idx_q <= rel_idx_q + AW'(1);
				end
			end
			if (cmd.newline) begin
				pos_q    <= '0;
				col_q    <= '0;
				ovf_q    <= 1'b0;
				pcount_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_group) begin
			c_q <= char_byte;
		end
		if (cmd.store_in) begin
			grp_q[col_q] <= char_byte;
		end
		if (cmd.finish_group) begin
			grp_q[0] <= c_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_wr) begin
			pend_mem[pcount_q[AW-1:0]] <= (cur == CH_TAB);
		end
		rd_q <= pend_mem[rel_idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.raw_out) begin
			out_byte_q <= char_byte;
			line_end_q <= 1'b0;
			overflow_q <= 1'b0;
		end else if (cmd.put_char) begin
			out_byte_q <= cur;
			line_end_q <= 1'b0;
			overflow_q <= 1'b0;
		end else if (cmd.rel_put) begin
			out_byte_q <= rd_q ? CH_TAB : CH_SPACE;
			line_end_q <= 1'b0;
			overflow_q <= 1'b0;
		end else if (cmd.newline) begin
			out_byte_q <= CH_NEWLINE;
			line_end_q <= 1'b1;
			overflow_q <= ovf_q;
		end
	end

	assign result_valid = out_valid_q;
	assign out_byte     = out_byte_q;
	assign line_end     = line_end_q;
	assign overflow     = overflow_q;

endmodule

// ----- hdl/stl_ctrl.sv -----
// Controller of the line compressor: sequences group scans, blank release and
// line ends. Drives stl_dpath through cmd_t and reads sts_t; depends on stl_pkg.
module stl_ctrl
	import stl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  sts_t sts,
	output cmd_t cmd,
	output logic item_stall
);

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_REL_RD, ST_REL_WR, ST_NL} state_t;

	state_t state_q;
	logic   end_q;
	logic   accept;

	assign item_stall = (state_q != ST_IDLE) || !sts.slot_free;
	assign accept     = (state_q == ST_IDLE) && item_valid && sts.slot_free;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.take = 1'b1;
					if (sts.in_end) begin
						if (sts.comp && sts.pos_nz) begin
							cmd.start_fill = 1'b1;
						end else begin
							cmd.newline = 1'b1;
						end
					end else if (sts.in_full) begin
						cmd.drop = 1'b1;
					end else if (!sts.comp) begin
						cmd.raw_out = 1'b1;
					end else if (sts.boundary) begin
						cmd.start_group = 1'b1;
					end else begin
						cmd.store_in = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					cmd.finish_group = !end_q;
				end else if (sts.cur_blank) begin
					cmd.hold_blank = 1'b1;
				end else if (sts.pend_zero && sts.slot_free) begin
					cmd.put_char = 1'b1;
				end
			end
			ST_REL_WR: begin
				cmd.rel_put = sts.slot_free;
			end
			ST_NL: begin
				cmd.newline = sts.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			end_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start_fill) begin
						end_q   <= 1'b1;
						state_q <= ST_SCAN;
					end else if (cmd.start_group) begin
						end_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= end_q ? ST_NL : ST_IDLE;
					end else if (!sts.cur_blank && !sts.pend_zero) begin
						state_q <= ST_REL_RD;
					end
				end
				ST_REL_RD: begin
					state_q <= ST_REL_WR;
				end
				ST_REL_WR: begin
					if (sts.slot_free) begin
						state_q <= sts.rel_last ? ST_SCAN : ST_REL_RD;
					end
				end
				ST_NL: begin
					if (sts.slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/space_to_tab_line_compressor.sv -----
// Top level of the space-to-tab line compressor: joins stl_ctrl and stl_dpath.
// Depends on stl_pkg, stl_ctrl and stl_dpath.
//
// Usage: a line enters one character per transfer on the item channel
// (req_type 0, char_byte), closed by a transfer with req_type 1. Results leave
// on the result channel as out_byte, with line_end and overflow set on the
// closing newline. compress_enable is written through cfg_valid/cfg_ready
// (always ready) and takes effect from the next line; the user must write it
// only while the block is idle, which the block does not enforce. With
// compression off, or for an empty line, the result appears the cycle after
// the transfer. With compression on a character is stored; the character that
// opens a new tab group, and the end of line, start a walk of the finished
// group: each entry up to its last non-space and then a trailing space or tab,
// or at line end every stored entry. Each non-blank after held blanks first
// releases them, each by a registered read and an output. A walk ends by
// storing the waiting character, or at line end by sending the newline. The
// item channel is stalled during a walk and while a stalled result holds the
// output register; each step that loads a result waits for it. Reset clears
// position, counters, mode and output valid at once, with no clearing pass.
module space_to_tab_line_compressor
	import stl_pkg::*;
#(
	parameter int TAB_WIDTH = 8,
	parameter int LINE_MAX  = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       compress_enable,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       req_type,
	input  logic [7:0] char_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic       line_end,
	output logic       overflow
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	stl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.sts        (sts),
		.cmd        (cmd),
		.item_stall (item_stall)
	);

	stl_dpath #(
		.TAB_WIDTH (TAB_WIDTH),
		.LINE_MAX  (LINE_MAX)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_bit      (compress_enable),
		.req_type     (req_type),
		.char_byte    (char_byte),
		.result_stall (result_stall),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.out_byte     (out_byte),
		.line_end     (line_end),
		.overflow     (overflow)
	);

endmodule
